[sv/json_string_escaper_top_assert.svh]
// Assertion macros shared by the checker of the JSON string escaper.
`ifndef JSON_STRING_ESCAPER_TOP_ASSERT_SVH
`define JSON_STRING_ESCAPER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define JSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define JSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/jse_pkg.sv]
`timescale 1ns / 1ps

package jse_pkg;

  localparam int LIMIT_W     = 14;
  localparam int MAX_RESULTS = 8;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_FF        = 8'h0C;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LOWER_B   = 8'h62;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_U   = 8'h75;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               last_of_run;
    logic               string_done;
    logic               overflow_error;
    logic [LIMIT_W-1:0] total_length;
  } out_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = CH_ZERO + {4'd0, nib};
    end else begin
      d = CH_LOWER_A + {4'd0, nib - 4'd10};
    end
    return d;
  endfunction

endpackage

[sv/json_string_escaper_top.sv]
`timescale 1ns / 1ps
// A request waits in the input register a_data_r until the result buffer run_bytes_r is free.
// Throughput: one request per cycle when out_stall is low and each gives one result; a
// request with n results holds the buffer until the single output byte port sends all n.
// Reset (synchronous, rst_n low) empties both stages, clears the string state and
// sets the output limit to 1203.

module json_string_escaper_top #(
  parameter int MAX_OUTPUT = 8192
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  jse_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output jse_pkg::out_t                out_data,
  input  logic                         cfg_we,
  input  logic [jse_pkg::LIMIT_W-1:0]  cfg_wdata
);

  localparam int CNT_W = ($clog2(MAX_OUTPUT + 8) > jse_pkg::LIMIT_W) ?
                         $clog2(MAX_OUTPUT + 8) : jse_pkg::LIMIT_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_OUTPUT);
  localparam int NRES = jse_pkg::MAX_RESULTS;

  logic [jse_pkg::LIMIT_W-1:0] limit_cfg_r;
  logic                        a_valid_r;
  jse_pkg::in_t                a_data_r;
  logic                        in_string_r, in_string_nxt;
  logic                        discarding_r, discarding_nxt;
  logic [CNT_W-1:0]            out_count_r, out_count_nxt;
  logic [7:0]                  run_bytes_r [NRES];
  logic [3:0]                  run_cnt_r;
  logic                        run_done_r, run_err_r;
  logic [jse_pkg::LIMIT_W-1:0] run_total_r;

  logic [CNT_W-1:0]            lim, base, cnt_fin;
  logic [7:0]                  c, esc;
  logic                        ends, start, uni, fail;
  logic [7:0]                  ch [8];
  logic [2:0]                  chn, jdx;
  logic [7:0]                  res_bytes [NRES];
  logic [3:0]                  res_n;
  logic                        res_done, res_err;
  logic [jse_pkg::LIMIT_W-1:0] res_total;
  logic                        run_free, a_take, out_fire;

  always_comb begin
    lim = (CNT_W'(limit_cfg_r) > MAX_CNT) ? MAX_CNT : CNT_W'(limit_cfg_r);
    c     = a_data_r.in_byte;
    ends  = (c == 8'd0) || a_data_r.end_of_string;
    start = !in_string_r;
    base  = start ? CNT_W'(1) : out_count_r;

    case (c)
      jse_pkg::CH_QUOTE:     esc = jse_pkg::CH_QUOTE;
      jse_pkg::CH_BACKSLASH: esc = jse_pkg::CH_BACKSLASH;
      jse_pkg::CH_BS:        esc = jse_pkg::CH_LOWER_B;
      jse_pkg::CH_FF:        esc = jse_pkg::CH_LOWER_F;
      jse_pkg::CH_LF:        esc = jse_pkg::CH_LOWER_N;
      jse_pkg::CH_CR:        esc = jse_pkg::CH_LOWER_R;
      jse_pkg::CH_TAB:       esc = jse_pkg::CH_LOWER_T;
      default:               esc = 8'd0;
    endcase

    for (int i = 0; i < 8; i++) begin
      ch[i] = 8'd0;
    end
    uni = 1'b0;
    if (c == 8'd0) begin
      chn = 3'd0;
    end else if (esc != 8'd0) begin
      chn   = 3'd2;
      ch[0] = jse_pkg::CH_BACKSLASH;
      ch[1] = esc;
    end else if (c >= jse_pkg::CH_SPACE) begin
      chn   = 3'd1;
      ch[0] = c;
    end else begin
      uni   = 1'b1;
      chn   = 3'd6;
      ch[0] = jse_pkg::CH_BACKSLASH;
      ch[1] = jse_pkg::CH_LOWER_U;
      ch[2] = jse_pkg::CH_ZERO;
      ch[3] = jse_pkg::CH_ZERO;
      ch[4] = jse_pkg::hex_digit(c[7:4]);
      ch[5] = jse_pkg::hex_digit(c[3:0]);
    end

    cnt_fin = base + CNT_W'(chn) + CNT_W'(ends);

    fail = (start && (lim < CNT_W'(3)))
        || ((c != 8'd0) && (base + CNT_W'(2) >= lim))
        || (uni && (base + CNT_W'(6) >= lim))
        || (ends && (base + CNT_W'(chn) + CNT_W'(1) >= lim));

    for (int i = 0; i < NRES; i++) begin
      jdx = 3'(i) - {2'd0, start};
      if (3'(i) < {2'd0, start}) begin
        res_bytes[i] = jse_pkg::CH_QUOTE;
      end else if (jdx < chn) begin
        res_bytes[i] = ch[jdx];
      end else begin
        res_bytes[i] = jse_pkg::CH_QUOTE;
      end
    end
    res_n     = {3'd0, start} + {1'b0, chn} + {3'd0, ends};
    res_done  = ends;
    res_err   = 1'b0;
    res_total = ends ? cnt_fin[jse_pkg::LIMIT_W-1:0] : '0;

    in_string_nxt  = in_string_r;
    discarding_nxt = discarding_r;
    out_count_nxt  = out_count_r;
    if (discarding_r) begin
      res_n = 4'd0;
      if (ends) begin
        discarding_nxt = 1'b0;
        in_string_nxt  = 1'b0;
        out_count_nxt  = '0;
      end
    end else if (fail) begin
      res_bytes[0]   = 8'd0;
      res_n          = 4'd1;
      res_done       = 1'b1;
      res_err        = 1'b1;
      res_total      = '0;
      in_string_nxt  = 1'b0;
      out_count_nxt  = '0;
      discarding_nxt = !ends;
    end else if (ends) begin
      in_string_nxt = 1'b0;
      out_count_nxt = '0;
    end else begin
      in_string_nxt = 1'b1;
      out_count_nxt = cnt_fin;
    end
  end

  assign out_fire = (run_cnt_r != 4'd0) && !out_stall;
  assign run_free = (run_cnt_r == 4'd0) || ((run_cnt_r == 4'd1) && !out_stall);
  assign a_take   = a_valid_r && (run_free || (res_n == 4'd0));
  assign in_stall = a_valid_r && !a_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_cfg_r  <= jse_pkg::LIMIT_W'(1203);
      a_valid_r    <= 1'b0;
      in_string_r  <= 1'b0;
      discarding_r <= 1'b0;
      out_count_r  <= '0;
      run_cnt_r    <= 4'd0;
    end else begin
      if (cfg_we) begin
        limit_cfg_r <= cfg_wdata;
      end
      if (!in_stall) begin
        a_valid_r <= in_valid;
      end
      if (a_take) begin
        in_string_r  <= in_string_nxt;
        discarding_r <= discarding_nxt;
        out_count_r  <= out_count_nxt;
      end
      if (a_take && (res_n != 4'd0)) begin
        run_cnt_r <= res_n;
      end else if (out_fire) begin
        run_cnt_r <= run_cnt_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      a_data_r <= in_data;
    end
    if (a_take && (res_n != 4'd0)) begin
      for (int i = 0; i < NRES; i++) begin
        run_bytes_r[i] <= res_bytes[i];
      end
      run_done_r  <= res_done;
      run_err_r   <= res_err;
      run_total_r <= res_total;
    end else if (out_fire) begin
      for (int i = 0; i < NRES - 1; i++) begin
        run_bytes_r[i] <= run_bytes_r[i+1];
      end
    end
  end

  always_comb begin
    out_valid               = (run_cnt_r != 4'd0);
    out_data.out_byte       = run_bytes_r[0];
    out_data.last_of_run    = (run_cnt_r == 4'd1);
    out_data.string_done    = (run_cnt_r == 4'd1) && run_done_r;
    out_data.overflow_error = (run_cnt_r == 4'd1) && run_err_r;
    out_data.total_length   = (run_cnt_r == 4'd1) ? run_total_r : '0;
  end

endmodule

[sv/jse_checker.sv]
`timescale 1ns / 1ps
`include "json_string_escaper_top_assert.svh"

module jse_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input jse_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input jse_pkg::out_t out_data
);

  logic out_wait;
  logic in_wait;
  logic err_ok;
  logic done_seen;
  logic open_seen;
  logic total_zero;

  assign out_wait   = out_valid && out_stall;
  assign in_wait    = in_valid && in_stall;
  assign err_ok     = out_data.string_done && out_data.last_of_run &&
                      (out_data.out_byte == 8'd0) && (out_data.total_length == '0);
  assign done_seen  = out_valid && out_data.string_done;
  assign open_seen  = out_valid && !out_data.string_done;
  assign total_zero = (out_data.total_length == '0);

  `JSE_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_data), "Stalled request changed")
  `JSE_ASSERT_NEXT(a_in_hold, in_wait, in_valid && $stable(in_data), "Stalled input changed")
  `JSE_ASSERT_NOW(a_err_shape, out_valid && out_data.overflow_error, err_ok, "Bad error request")
  `JSE_ASSERT_NOW(a_done_last, done_seen, out_data.last_of_run, "Done off the last request")
  `JSE_ASSERT_NOW(a_total_zero, open_seen, total_zero, "Length before the string ended")

endmodule

bind json_string_escaper_top jse_checker u_jse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[tb/sv/json_string_escaper_top_tb.sv]
`timescale 1ns / 1ps

module json_string_escaper_top_tb;

  localparam int unsigned OUT_CAP     = 8192;
  localparam int          ITEM_TARGET = 270;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 120;
  localparam int          SETTLE      = 6;

  class escape_tracker;
    logic [jse_pkg::LIMIT_W-1:0] limit_reg = 14'd1203;
    bit                          in_string;
    bit                          discarding;
    int unsigned                 out_count;
    jse_pkg::out_t               expected_chars[$];
    int                          fault_count;
    int                          request_count;
    int                          dropped_count;
    int                          result_count;
    int                          closed_count;
    int                          overflow_count;

    function void set_limit(logic [jse_pkg::LIMIT_W-1:0] v);
      limit_reg = v;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function void note_request(jse_pkg::in_t req);
      logic [7:0]    c;
      logic [7:0]    esc;
      logic [7:0]    emitted[$];
      logic          ends;
      logic          failed;
      int unsigned   lim;
      int unsigned   cnt;
      jse_pkg::out_t r;
      c = req.in_byte;
      ends = (c == 8'd0) || req.end_of_string;
      lim = (limit_reg > OUT_CAP) ? OUT_CAP : limit_reg;
      failed = 1'b0;
      request_count++;
      if (discarding) begin
        dropped_count++;
        if (ends) begin
          discarding = 1'b0;
          in_string = 1'b0;
          out_count = 0;
        end
        return;
      end
      cnt = out_count;
      if (!in_string) begin
        if (lim < 3) begin
          failed = 1'b1;
        end else begin
          emitted.push_back(jse_pkg::CH_QUOTE);
          cnt = 1;
        end
      end
      if (!failed && c != 8'd0) begin
        case (c)
          jse_pkg::CH_QUOTE:     esc = jse_pkg::CH_QUOTE;
          jse_pkg::CH_BACKSLASH: esc = jse_pkg::CH_BACKSLASH;
          jse_pkg::CH_BS:        esc = jse_pkg::CH_LOWER_B;
          jse_pkg::CH_FF:        esc = jse_pkg::CH_LOWER_F;
          jse_pkg::CH_LF:        esc = jse_pkg::CH_LOWER_N;
          jse_pkg::CH_CR:        esc = jse_pkg::CH_LOWER_R;
          jse_pkg::CH_TAB:       esc = jse_pkg::CH_LOWER_T;
          default:               esc = 8'd0;
        endcase
        if (cnt + 2 >= lim) begin
          failed = 1'b1;
        end else if (esc != 8'd0) begin
          emitted.push_back(jse_pkg::CH_BACKSLASH);
          emitted.push_back(esc);
          cnt += 2;
        end else if (c >= jse_pkg::CH_SPACE) begin
          emitted.push_back(c);
          cnt += 1;
        end else if (cnt + 6 >= lim) begin
          failed = 1'b1;
        end else begin
          emitted.push_back(jse_pkg::CH_BACKSLASH);
          emitted.push_back(jse_pkg::CH_LOWER_U);
          emitted.push_back(jse_pkg::CH_ZERO);
          emitted.push_back(jse_pkg::CH_ZERO);
          emitted.push_back(jse_pkg::CH_ZERO + {4'd0, c[7:4]});
          emitted.push_back((c[3:0] < 4'd10) ? jse_pkg::CH_ZERO + {4'd0, c[3:0]}
                            : jse_pkg::CH_LOWER_A + {4'd0, c[3:0]} - 8'd10);
          cnt += 6;
        end
      end
      if (!failed && ends) begin
        if (cnt + 1 >= lim) begin
          failed = 1'b1;
        end else begin
          emitted.push_back(jse_pkg::CH_QUOTE);
          cnt += 1;
        end
      end
      if (failed) begin
        in_string = 1'b0;
        out_count = 0;
        discarding = !ends;
        r = '0;
        r.last_of_run = 1'b1;
        r.string_done = 1'b1;
        r.overflow_error = 1'b1;
        expected_chars.push_back(r);
        return;
      end
      foreach (emitted[k]) begin
        r = '0;
        r.out_byte = emitted[k];
        r.last_of_run = (k == emitted.size() - 1);
        r.string_done = ends && r.last_of_run;
        r.total_length = r.string_done ? jse_pkg::LIMIT_W'(cnt) : '0;
        expected_chars.push_back(r);
      end
      in_string = !ends;
      out_count = ends ? 0 : cnt;
    endfunction

    function void report(string field, int unsigned want_v, int unsigned got_v);
      fault_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
    endfunction

    function void check_result(jse_pkg::out_t got);
      jse_pkg::out_t want;
      result_count++;
      if (got.string_done && !got.overflow_error) closed_count++;
      if (got.overflow_error) overflow_count++;
      if (expected_chars.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        return;
      end
      want = expected_chars.pop_front();
      if (got.out_byte !== want.out_byte)
        report("out_byte", want.out_byte, got.out_byte);
      if (got.last_of_run !== want.last_of_run)
        report("last_of_run", want.last_of_run, got.last_of_run);
      if (got.string_done !== want.string_done)
        report("string_done", want.string_done, got.string_done);
      if (got.overflow_error !== want.overflow_error)
        report("overflow_error", want.overflow_error, got.overflow_error);
      if (got.total_length !== want.total_length)
        report("total_length", want.total_length, got.total_length);
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  jse_pkg::in_t                in_data;
  logic                        out_valid;
  logic                        out_stall;
  jse_pkg::out_t               out_data;
  logic                        cfg_we;
  logic [jse_pkg::LIMIT_W-1:0] cfg_wdata;

  escape_tracker tracker = new();
  int            burst_left;
  bit            steady;
  bit            hold_wanted;
  bit            hold_done;
  int            limit_writes;
  int            input_stalls;
  int            sent_count;

  json_string_escaper_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) tracker.set_limit(cfg_wdata);
      if (in_valid && !in_stall) tracker.note_request(in_data);
      if (in_valid && in_stall) input_stalls++;
      if (out_valid && !out_stall) tracker.check_result(out_data);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // The receiver stalls in segments of differing density, and once holds off for a
  // long stretch so that the block backs up onto its input.
  initial begin : receiver
    int seg_left;
    int seg_mode;
    seg_left = 0;
    seg_mode = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_wanted && !hold_done) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 3);
        seg_left = $urandom_range(5, 60);
      end
      seg_left--;
      case (seg_mode)
        0:       out_stall = 1'b0;
        1:       out_stall = ($urandom_range(0, 3) == 0);
        2:       out_stall = $urandom_range(0, 1);
        default: out_stall = ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eos);
    if (burst_left == 0 && !steady) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left != 0) burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_data.in_byte = b;
    in_data.end_of_string = eos;
    sent_count++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_limit(input logic [jse_pkg::LIMIT_W-1:0] v);
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    limit_writes++;
  endtask

  function automatic logic [7:0] random_char();
    logic [7:0] esc_set[7];
    esc_set = '{jse_pkg::CH_QUOTE, jse_pkg::CH_BACKSLASH, jse_pkg::CH_BS, jse_pkg::CH_FF,
                jse_pkg::CH_LF, jse_pkg::CH_CR, jse_pkg::CH_TAB};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 8'($urandom_range(8'h20, 8'h7E));
      5:             return esc_set[$urandom_range(0, 6)];
      6:             return 8'($urandom_range(8'h01, 8'h1F));
      7, 8:          return 8'($urandom_range(8'h80, 8'hFF));
      default:       return 8'($urandom_range(8'h01, 8'hFF));
    endcase
  endfunction

  function automatic logic [jse_pkg::LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return jse_pkg::LIMIT_W'($urandom_range(0, 2));
      1, 2:    return jse_pkg::LIMIT_W'($urandom_range(3, 8));
      3, 4:    return jse_pkg::LIMIT_W'($urandom_range(9, 24));
      5:       return jse_pkg::LIMIT_W'($urandom_range(25, 60));
      6:       return 14'd1203;
      7:       return 14'd8192;
      8:       return jse_pkg::LIMIT_W'($urandom_range(8193, 16383));
      default: return 14'd16383;
    endcase
  endfunction

  task automatic send_random_string();
    int len;
    int term;
    len = $urandom_range(0, 10);
    if ($urandom_range(0, 9) == 0) len = $urandom_range(11, 40);
    term = $urandom_range(0, 3);
    for (int i = 0; i < len; i++)
      push_byte(random_char(), (term < 2) && (i == len - 1));
    if (term >= 2 || len == 0) push_byte(8'd0, term == 3);
  endtask

  initial begin : stimulus
    int since_write;
    int next_write;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    burst_left = 0;
    steady = 1'b0;
    hold_wanted = 1'b0;
    hold_done = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    push_byte("A", 1'b1);
    push_byte(jse_pkg::CH_QUOTE, 1'b0);
    push_byte(jse_pkg::CH_BACKSLASH, 1'b0);
    push_byte(jse_pkg::CH_BS, 1'b0);
    push_byte(jse_pkg::CH_FF, 1'b0);
    push_byte(jse_pkg::CH_LF, 1'b0);
    push_byte(jse_pkg::CH_CR, 1'b0);
    push_byte(jse_pkg::CH_TAB, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h1F, 1'b0);
    push_byte(jse_pkg::CH_SPACE, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    write_limit(14'd2);
    push_byte("x", 1'b1);
    write_limit(14'd0);
    push_byte(8'h00, 1'b0);
    write_limit(14'd3);
    push_byte(8'h00, 1'b1);
    push_byte("a", 1'b0);
    push_byte("b", 1'b0);
    push_byte(8'h00, 1'b0);
    write_limit(14'd7);
    push_byte(8'h03, 1'b1);
    write_limit(14'd1203);
    push_byte("m", 1'b0);
    write_limit(14'd4);
    push_byte("n", 1'b1);
    write_limit(14'd16383);
    push_byte("q", 1'b1);

    write_limit(14'd1203);
    hold_wanted = 1'b1;
    steady = 1'b1;
    for (int i = 0; i < 30; i++) push_byte(random_char(), i == 29);
    steady = 1'b0;

    since_write = 0;
    next_write = 0;
    while (tracker.request_count < ITEM_TARGET) begin
      if (since_write >= next_write) begin
        write_limit(pick_limit());
        since_write = 0;
        next_write = $urandom_range(20, 50);
      end
      next_write += sent_count;
      if ($urandom_range(0, 6) == 0)
        push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else
        send_random_string();
      next_write -= sent_count;
      since_write = 0;
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d requests (%0d dropped after overflow), %0d result bytes,",
             tracker.request_count, tracker.dropped_count, tracker.result_count);
    $display("%0d strings closed, %0d overflow errors, %0d limit writes, %0d stall cycles.",
             tracker.closed_count, tracker.overflow_count, limit_writes, input_stalls);
    if (tracker.fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
